/* src/ghs_pkg.sv */
// shared types, constants and the tap weight lookup for the histogram smoother
// no dependencies
package ghs_pkg;

    localparam int MAX_BINS_DEF       = 64;
    localparam int MAX_HALF_WIDTH_DEF = 7;
    localparam int CFG_INDEX_W        = 2;
    localparam int CFG_DATA_W         = 64;

    localparam logic [CFG_INDEX_W-1:0] REG_HALF_WIDTH    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PERIODIC_MODE = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_WEIGHTS_NEAR  = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_WEIGHTS_FAR   = 2'd3;

    typedef struct packed {
        logic signed [31:0] sample;
        logic               last_sample;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] smoothed;
        logic [5:0]         bin_index;
        logic               last_result;
        logic               overflowed;
    } out_item_t;

    typedef struct packed {
        logic [2:0]  half_width;
        logic        periodic_mode;
        logic [63:0] weights_near;
        logic [63:0] weights_far;
    } cfg_t;

    // q1.15 weight for a distance, zero past seven
    function automatic logic [15:0] weight_of(input logic [63:0] near, input logic [63:0] far,
                                              input logic [3:0] d);
        logic [15:0] w;
        begin
            case (d)
                4'd0:    w = near[15:0];
                4'd1:    w = near[31:16];
                4'd2:    w = near[47:32];
                4'd3:    w = near[63:48];
                4'd4:    w = far[15:0];
                4'd5:    w = far[31:16];
                4'd6:    w = far[47:32];
                4'd7:    w = far[63:48];
                default: w = 16'd0;
            endcase
            return w;
        end
    endfunction

endpackage

/* src/ghs_loader.sv */
// front end: accepts samples, writes them into the current bank, posts a job per channel
// depends on ghs_pkg
module ghs_loader #(
    parameter int MAX_BINS = 64,
    parameter int IDX_W    = 6,
    parameter int CNT_W    = 7
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  ghs_pkg::in_item_t    in_item,
    input  logic                 q_full,
    output logic                 push,
    output logic [CNT_W+1:0]     job,
    output logic                 wr_en,
    output logic [IDX_W:0]       wr_addr,
    output logic [31:0]          wr_data
);
    import ghs_pkg::*;

    logic [CNT_W-1:0] count_reg, count_next;
    logic             ovf_reg, ovf_next;
    logic             bank_reg, bank_next;
    logic             accept;
    logic             room;
    logic [CNT_W-1:0] job_n;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign room     = count_reg < CNT_W'(MAX_BINS);
    assign wr_en    = accept && room;
    assign wr_addr  = {bank_reg, count_reg[IDX_W-1:0]};
    assign wr_data  = in_item.sample;
    assign job_n    = room ? count_reg + CNT_W'(1) : count_reg;
    assign push     = accept && in_item.last_sample;
    assign job      = {bank_reg, ovf_reg || !room, job_n};

    always_comb
    begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        bank_next  = bank_reg;
        if (accept)
        begin
            if (in_item.last_sample)
            begin
                count_next = '0;
                ovf_next   = 1'b0;
                bank_next  = !bank_reg;
            end
            else if (room)
            begin
                count_next = count_reg + CNT_W'(1);
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            bank_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            bank_reg  <= bank_next;
        end
    end

endmodule

/* src/ghs_job_queue.sv */
// two-entry queue of loaded channels between loader and smoothing engine
// depends on ghs_pkg
module ghs_job_queue #(
    parameter int W = 9
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] push_data,
    input  logic         pop,
    output logic         full,
    output logic         head_valid,
    output logic [W-1:0] head
);
    import ghs_pkg::*;

    logic [W-1:0] slot_reg [2];
    logic         rd_ptr_reg, wr_ptr_reg;
    logic [1:0]   cnt_reg, cnt_next;

    assign full       = cnt_reg == 2'd2;
    assign head_valid = cnt_reg != 2'd0;
    assign head       = slot_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 2'd1;
        else if (pop && !push)
            cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
        end
    end

endmodule

/* src/ghs_engine.sv */
// back end: two-bank bin memory, tap sequencer with one multiplier, serial divider
// depends on ghs_pkg
module ghs_engine #(
    parameter int MAX_BINS       = 64,
    parameter int MAX_HALF_WIDTH = 7,
    parameter int IDX_W          = 6,
    parameter int CNT_W          = 7
) (
    input  logic               clk,
    input  logic               rst_n,
    input  ghs_pkg::cfg_t      cfg,
    input  logic               wr_en,
    input  logic [IDX_W:0]     wr_addr,
    input  logic [31:0]        wr_data,
    input  logic               job_valid,
    input  logic [CNT_W+1:0]   job,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output ghs_pkg::out_item_t out_item
);
    import ghs_pkg::*;

    localparam int HW_W    = $clog2(MAX_HALF_WIDTH + 1);
    localparam int TAP_W   = $clog2(2 * MAX_HALF_WIDTH + 2);
    localparam int ACC_W   = 48 + TAP_W;
    localparam int NORM_W  = 16 + TAP_W;
    localparam int NUM_W   = ACC_W + 1;
    localparam int DCNT_W  = $clog2(NUM_W + 1);
    localparam int J_W     = CNT_W + HW_W + 2;
    localparam int CW      = CNT_W + HW_W + 3;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_TAP   = 5'b00010,
        S_DRAIN = 5'b00100,
        S_DIV   = 5'b01000,
        S_OUT   = 5'b10000
    } state_t;

    logic [31:0] mem [2*MAX_BINS];
    logic [31:0] rd_data_reg;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     n_reg, n_next;
    logic                 ovf_reg, ovf_next;
    logic                 bank_reg, bank_next;
    logic [HW_W-1:0]      hw_reg, hw_next;
    logic [IDX_W-1:0]     i_reg, i_next;
    logic signed [HW_W:0] t_reg, t_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic [NORM_W-1:0]    norm_reg, norm_next;
    logic [NUM_W-1:0]     num_reg, num_next;
    logic [NORM_W:0]      den_reg, den_next;
    logic [NORM_W:0]      rem_reg, rem_next;
    logic [DCNT_W-1:0]    dcnt_reg, dcnt_next;
    logic                 neg_reg, neg_next;
    logic                 out_valid_reg, out_valid_next;
    out_item_t            out_item_reg, out_item_next;

    logic                 p1_reg, v1_reg, p2_reg, v2_reg;
    logic [15:0]          w1_reg, w2_reg;
    logic signed [47:0]   prod_reg;

    logic [CNT_W-1:0]     q_n;
    logic [CW-1:0]        hw_a, lim;
    logic signed [J_W-1:0] j, nj, k;
    logic                 take_tap;
    logic [HW_W:0]        dabs;
    logic [15:0]          w_tap;
    logic                 issue;
    logic [IDX_W:0]       rd_addr;
    logic [ACC_W-1:0]     mag;
    logic [NORM_W+1:0]    rem_sh;
    logic                 ge;
    logic [NUM_W-1:0]     qcap, qsat;
    logic [IDX_W+5:0]     iext;
    logic                 is_last;

    assign q_n = job[CNT_W-1:0];

    always_comb
    begin
        hw_a = CW'(cfg.half_width);
        if (hw_a > CW'(MAX_HALF_WIDTH))
            hw_a = CW'(MAX_HALF_WIDTH);
        lim = CW'(q_n) - CW'(1);
        if (hw_a > lim)
            hw_a = lim;
    end

    // tap address, wrapping or clipping against the channel ends
    always_comb
    begin
        j  = J_W'(signed'({1'b0, i_reg})) + J_W'(t_reg);
        nj = J_W'(signed'({1'b0, n_reg}));
        if (j < 0)
            k = j + nj;
        else if (j >= nj)
            k = j - nj;
        else
            k = j;
        take_tap = cfg.periodic_mode || ((j >= 0) && (j < nj));
        dabs     = t_reg[HW_W] ? (HW_W+1)'(-t_reg) : t_reg;
        w_tap    = weight_of(cfg.weights_near, cfg.weights_far, 4'(dabs));
    end

    assign issue   = state_reg == S_TAP;
    assign rd_addr = {bank_reg, k[IDX_W-1:0]};

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[rd_addr];
    end

    // multiply then accumulate, one stage each
    always_ff @(posedge clk)
    begin
        w1_reg   <= w_tap;
        w2_reg   <= w1_reg;
        prod_reg <= 48'(signed'(rd_data_reg)) * 48'(signed'({1'b0, w1_reg}));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_reg <= 1'b0;
            v1_reg <= 1'b0;
            p2_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            p1_reg <= issue;
            v1_reg <= issue && take_tap;
            p2_reg <= p1_reg;
            v2_reg <= v1_reg;
        end
    end

    always_comb
    begin
        mag    = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
        rem_sh = {rem_reg, num_reg[NUM_W-1]};
        ge     = rem_sh >= {1'b0, den_reg};
        qcap   = neg_reg ? NUM_W'(33'h1_0000_0000 >> 1) : NUM_W'(32'h7fff_ffff);
        qsat   = (num_reg > qcap) ? qcap : num_reg;
        iext   = (IDX_W+6)'(i_reg);
        is_last = (CNT_W'(i_reg) + CNT_W'(1)) == n_reg;
    end

    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        ovf_next       = ovf_reg;
        bank_next      = bank_reg;
        hw_next        = hw_reg;
        i_next         = i_reg;
        t_next         = t_reg;
        acc_next       = acc_reg;
        norm_next      = norm_reg;
        num_next       = num_reg;
        den_next       = den_reg;
        rem_next       = rem_reg;
        dcnt_next      = dcnt_reg;
        neg_next       = neg_reg;
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        pop            = 1'b0;

        if (v2_reg)
        begin
            acc_next  = acc_reg + ACC_W'(prod_reg);
            norm_next = norm_reg + NORM_W'(w2_reg);
        end

        case (state_reg)
            S_IDLE:
            begin
                if (job_valid)
                begin
                    n_next     = q_n;
                    ovf_next   = job[CNT_W];
                    bank_next  = job[CNT_W+1];
                    hw_next    = hw_a[HW_W-1:0];
                    i_next     = '0;
                    t_next     = -signed'((HW_W+1)'(hw_a[HW_W-1:0]));
                    acc_next   = '0;
                    norm_next  = '0;
                    state_next = S_TAP;
                end
            end
            S_TAP:
            begin
                t_next = t_reg + (HW_W+1)'(1);
                if (t_reg == signed'({1'b0, hw_reg}))
                    state_next = S_DRAIN;
            end
            S_DRAIN:
            begin
                if (!p1_reg && !p2_reg)
                begin
                    if (norm_reg == '0)
                    begin
                        out_item_next.smoothed = '0;
                        state_next             = S_OUT;
                        out_valid_next         = 1'b1;
                    end
                    else
                    begin
                        neg_next   = acc_reg[ACC_W-1];
                        num_next   = (NUM_W'(mag) << 1) + NUM_W'(norm_reg);
                        den_next   = (NORM_W+1)'(norm_reg) << 1;
                        rem_next   = '0;
                        dcnt_next  = DCNT_W'(NUM_W);
                        state_next = S_DIV;
                    end
                    out_item_next.bin_index   = iext[5:0];
                    out_item_next.last_result = is_last;
                    out_item_next.overflowed  = ovf_reg;
                end
            end
            S_DIV:
            begin
                if (dcnt_reg == '0)
                begin
                    out_item_next.smoothed = neg_reg ? -signed'(qsat[31:0])
                                                     : signed'(qsat[31:0]);
                    out_valid_next = 1'b1;
                    state_next     = S_OUT;
                end
                else
                begin
                    rem_next  = ge ? (NORM_W+1)'(rem_sh - {1'b0, den_reg})
                                   : rem_sh[NORM_W:0];
                    num_next  = {num_reg[NUM_W-2:0], ge};
                    dcnt_next = dcnt_reg - DCNT_W'(1);
                end
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    out_valid_next = 1'b0;
                    if (is_last)
                    begin
                        pop        = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        i_next     = i_reg + IDX_W'(1);
                        t_next     = -signed'({1'b0, hw_reg});
                        acc_next   = '0;
                        norm_next  = '0;
                        state_next = S_TAP;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        n_reg        <= n_next;
        ovf_reg      <= ovf_next;
        bank_reg     <= bank_next;
        hw_reg       <= hw_next;
        i_reg        <= i_next;
        t_reg        <= t_next;
        acc_reg      <= acc_next;
        norm_reg     <= norm_next;
        num_reg      <= num_next;
        den_reg      <= den_next;
        rem_reg      <= rem_next;
        dcnt_reg     <= dcnt_next;
        neg_reg      <= neg_next;
        out_item_reg <= out_item_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

/* src/gaussian_histogram_smoother.sv */
// Gaussian histogram smoother, top level
// Input channel: in_valid/in_ready with in_item (sample, last_sample). Bins of one
// channel arrive in order; the item marked last_sample closes the channel. Samples
// past MAX_BINS are dropped and the channel's results carry overflowed.
// Output channel: out_valid/out_ready with out_item, one item per loaded bin, in bin
// order, last_result on the final bin.
// Config: cfg_we/cfg_index/cfg_data write half_width, periodic_mode, weights_near,
// weights_far; write only while the block is idle.
// Samples load while the job queue has room. The loader fills one of two memory
// banks while the engine smooths the other, so the next channel can load during
// output; it waits only when both banks hold channels not yet emitted.
// Each result steps through the (2h+1) taps of its window, where h is the clamped half
// width, on the single 32x16 multiplier, drains the multiply pipeline, runs the
// bit-serial divider (skipped on a zero weight sum) and is presented until taken. A
// stalled out_ready holds the result register and the engine.
// Reset clears the loader count, the job queue and the engine state; bin memory is not
// cleared and needs no sweep. Config registers return to their reset values.
module gaussian_histogram_smoother #(
    parameter int MAX_BINS       = ghs_pkg::MAX_BINS_DEF,
    parameter int MAX_HALF_WIDTH = ghs_pkg::MAX_HALF_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  ghs_pkg::in_item_t                 in_item,
    output logic                              out_valid,
    input  logic                              out_ready,
    output ghs_pkg::out_item_t                out_item,
    input  logic                              cfg_we,
    input  logic [ghs_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [ghs_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import ghs_pkg::*;

    localparam int IDX_W = $clog2(MAX_BINS);
    localparam int CNT_W = $clog2(MAX_BINS + 1);
    localparam int JOB_W = CNT_W + 2;

    cfg_t             cfg_reg;
    logic             q_full, push, pop, job_valid;
    logic [JOB_W-1:0] job_in, job_head;
    logic             wr_en;
    logic [IDX_W:0]   wr_addr;
    logic [31:0]      wr_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.half_width    <= 3'd0;
            cfg_reg.periodic_mode <= 1'b0;
            cfg_reg.weights_near  <= 64'd32768;
            cfg_reg.weights_far   <= 64'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_HALF_WIDTH:    cfg_reg.half_width    <= cfg_data[2:0];
                REG_PERIODIC_MODE: cfg_reg.periodic_mode <= cfg_data[0];
                REG_WEIGHTS_NEAR:  cfg_reg.weights_near  <= cfg_data;
                REG_WEIGHTS_FAR:   cfg_reg.weights_far   <= cfg_data;
                default:           cfg_reg               <= cfg_reg;
            endcase
        end
    end

    ghs_loader #(
        .MAX_BINS (MAX_BINS),
        .IDX_W    (IDX_W),
        .CNT_W    (CNT_W)
    ) u_loader (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_item  (in_item),
        .q_full   (q_full),
        .push     (push),
        .job      (job_in),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data)
    );

    ghs_job_queue #(
        .W (JOB_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (job_in),
        .pop        (pop),
        .full       (q_full),
        .head_valid (job_valid),
        .head       (job_head)
    );

    ghs_engine #(
        .MAX_BINS       (MAX_BINS),
        .MAX_HALF_WIDTH (MAX_HALF_WIDTH),
        .IDX_W          (IDX_W),
        .CNT_W          (CNT_W)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .job_valid (job_valid),
        .job       (job_head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

endmodule

/* src/ghs_checker.sv */
// port-level checks for the histogram smoother, bound to the top level
// depends on ghs_pkg and gaussian_histogram_smoother
module ghs_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_ready,
    input ghs_pkg::out_item_t out_item
);
    import ghs_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
        else $error("result changed while stalled");

    // every result needs at least a tap and the pipeline drain, never back to back
    a_out_gap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready |=> !out_valid)
        else $error("results issued back to back");

    // no result during reset
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("result valid during reset");

endmodule

bind gaussian_histogram_smoother ghs_checker u_ghs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
);

/* verif/gaussian_histogram_smoother_tb.sv */
// self-checking bench for the gaussian histogram smoother: a queue-fed driver, an output monitor
// and an in-bench predictor of the smoothed bins; depends on ghs_pkg and the top level
module gaussian_histogram_smoother_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ghs_pkg::*;

    localparam int NBINS = 64;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    in_item_t in_item;
    logic out_valid;
    logic out_ready;
    out_item_t out_item;
    logic cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    gaussian_histogram_smoother u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
        .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // predictor state, updated as items are queued (the block takes them in the same order)
    cfg_t shadow_cfg;
    logic signed [31:0] bins_held [NBINS];
    int unsigned bins_loaded;
    logic dropped_any;

    in_item_t pending_items[$];
    out_item_t expected_bins[$];
    int errors;
    int bins_checked;
    int channels_sent;
    bit stall_long;
    bit driver_paused;

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    initial
    begin
        #200_000_000;
        $display("gaussian_histogram_smoother: mismatch");
        $finish;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        errors++;
        $display("error at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    endtask

    function automatic logic [15:0] tap_weight(input int unsigned d);
        logic [15:0] w;
        if (d < 4)
            w = shadow_cfg.weights_near[16*d +: 16];
        else if (d < 8)
            w = shadow_cfg.weights_far[16*(d-4) +: 16];
        else
            w = 16'd0;
        return w;
    endfunction

    function automatic logic signed [31:0] smooth_one(input int i, input int n, input int hw);
        longint acc;
        longint unsigned norm;
        longint unsigned mag;
        longint unsigned q;
        int lo;
        int hi;
        int k;
        int unsigned d;
        longint unsigned w;
        acc = 0;
        norm = 0;
        lo = i - hw;
        hi = i + hw;
        if (!shadow_cfg.periodic_mode)
        begin
            if (lo < 0) lo = 0;
            if (hi > n - 1) hi = n - 1;
        end
        for (int j = lo; j <= hi; j++)
        begin
            d = (j < i) ? i - j : j - i;
            w = tap_weight(d);
            k = j;
            if (k < 0) k += n;
            if (k >= n) k -= n;
            acc += longint'(bins_held[k]) * longint'(w);
            norm += w;
        end
        if (norm == 0)
            return 32'sd0;
        mag = (acc < 0) ? longint'(-acc) : acc;
        q = (2 * mag + norm) / (2 * norm);
        if (acc < 0)
        begin
            if (q > 64'd2147483648) q = 64'd2147483648;
            return 32'(-longint'(q));
        end
        if (q > 64'd2147483647) q = 64'd2147483647;
        return 32'(q);
    endfunction

    task automatic predict_item(input in_item_t it);
        int hw;
        out_item_t r;
        if (bins_loaded < NBINS)
        begin
            bins_held[bins_loaded] = it.sample;
            bins_loaded++;
        end
        else
            dropped_any = 1'b1;
        if (it.last_sample)
        begin
            hw = shadow_cfg.half_width;
            if (hw > bins_loaded - 1) hw = bins_loaded - 1;
            for (int i = 0; i < bins_loaded; i++)
            begin
                r.smoothed = smooth_one(i, bins_loaded, hw);
                r.bin_index = 6'(i);
                r.last_result = (i == bins_loaded - 1);
                r.overflowed = dropped_any;
                expected_bins.push_back(r);
            end
            bins_loaded = 0;
            dropped_any = 1'b0;
            channels_sent++;
        end
    endtask

    task automatic queue_item(input logic signed [31:0] s, input logic last);
        in_item_t it;
        it.sample = s;
        it.last_sample = last;
        pending_items.push_back(it);
        predict_item(it);
    endtask

    function automatic logic signed [31:0] rand_sample();
        logic signed [31:0] s;
        case ($urandom_range(0, 5))
            0: s = 32'sh7fffffff;
            1: s = 32'sh80000000;
            2: s = 32'($urandom_range(0, 200)) - 100;
            default: s = $urandom;
        endcase
        return s;
    endfunction

    task automatic queue_channel(input int n);
        for (int i = 0; i < n; i++)
            queue_item(rand_sample(), i == n - 1);
    endtask

    // wait until every queued item is in and every result is out
    task automatic wait_idle();
        while (pending_items.size() != 0 || expected_bins.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_HALF_WIDTH:    shadow_cfg.half_width = val[2:0];
            REG_PERIODIC_MODE: shadow_cfg.periodic_mode = val[0];
            REG_WEIGHTS_NEAR:  shadow_cfg.weights_near = val;
            default:           shadow_cfg.weights_far = val;
        endcase
    endtask

    task automatic write_all(input logic [2:0] hw, input logic per,
                             input logic [63:0] wn, input logic [63:0] wf);
        write_reg(REG_HALF_WIDTH, {61'd0, hw});
        write_reg(REG_PERIODIC_MODE, {63'd0, per});
        write_reg(REG_WEIGHTS_NEAR, wn);
        write_reg(REG_WEIGHTS_FAR, wf);
    endtask

    // acceptance is sampled at the rising edge
    logic in_ready_q;
    always @(posedge clk)
        in_ready_q <= in_valid && in_ready;

    // sender: bursts and gaps, holds valid until the item is taken
    int gap_left;
    int burst_left;
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_item <= '0;
            gap_left <= 0;
            burst_left <= 0;
        end
        else if (!(in_valid && !in_ready_q))
        begin
            // previous item was accepted (or none was offered)
            if (in_valid && in_ready_q)
                void'(pending_items.pop_front());
            if (driver_paused || pending_items.size() <= (in_valid && in_ready_q ? 0 : 0)
                || gap_left > 0)
            begin
                in_valid <= 1'b0;
                if (gap_left > 0) gap_left <= gap_left - 1;
            end
            else if (pending_items.size() > 0)
            begin
                in_valid <= 1'b1;
                in_item <= pending_items[0];
                if (burst_left > 0)
                    burst_left <= burst_left - 1;
                else
                begin
                    burst_left <= $urandom_range(0, 20);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
        end
    end

    // receiver stall pattern, with an occasional long hold-off
    int stall_cnt;
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_cnt <= 0;
        end
        else if (stall_long)
        begin
            out_ready <= 1'b0;
            stall_cnt <= 0;
        end
        else if (stall_cnt > 0)
        begin
            out_ready <= 1'b0;
            stall_cnt <= stall_cnt - 1;
        end
        else if ($urandom_range(0, 7) == 0)
        begin
            out_ready <= 1'b0;
            stall_cnt <= $urandom_range(0, 40);
        end
        else
            out_ready <= 1'b1;
    end

    // monitor
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_bins.size() == 0)
                report_mismatch("unexpected bin_index", out_item.bin_index, -1);
            else
            begin
                want = expected_bins.pop_front();
                bins_checked++;
                if (out_item.smoothed !== want.smoothed)
                    report_mismatch("smoothed", out_item.smoothed, want.smoothed);
                if (out_item.bin_index !== want.bin_index)
                    report_mismatch("bin_index", out_item.bin_index, want.bin_index);
                if (out_item.last_result !== want.last_result)
                    report_mismatch("last_result", out_item.last_result, want.last_result);
                if (out_item.overflowed !== want.overflowed)
                    report_mismatch("overflowed", out_item.overflowed, want.overflowed);
            end
        end
    end

    initial
    begin
        int n;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_HALF_WIDTH;
        cfg_data = '0;
        errors = 0;
        bins_checked = 0;
        channels_sent = 0;
        stall_long = 1'b0;
        driver_paused = 1'b0;
        bins_loaded = 0;
        dropped_any = 1'b0;
        shadow_cfg.half_width = 3'd0;
        shadow_cfg.periodic_mode = 1'b0;
        shadow_cfg.weights_near = 64'd32768;
        shadow_cfg.weights_far = 64'd0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: reset weights, single-bin channel, extremes
        queue_item(32'sh7fffffff, 1'b1);
        queue_item(32'sh80000000, 1'b0);
        queue_item(32'sh7fffffff, 1'b0);
        queue_item(32'sh00000001, 1'b1);
        wait_idle();

        // full weights, wide window, clipped edges; extreme samples with max weights
        write_all(3'd7, 1'b0, 64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff);
        for (int i = 0; i < 5; i++)
            queue_item(32'sh7fffffff, i == 4);
        for (int i = 0; i < 4; i++)
            queue_item(32'sh80000000, i == 3);
        wait_idle();

        // wrapping with a window wider than the channel, and zero weight sum
        write_reg(REG_PERIODIC_MODE, 64'd1);
        queue_item(32'sd3, 1'b0);
        queue_item(-32'sd5, 1'b0);
        queue_item(32'sd1, 1'b1);
        wait_idle();
        write_all(3'd2, 1'b1, 64'd0, 64'd0);
        queue_channel(3);
        wait_idle();

        // overflow: more than capacity, last sample dropped too
        write_all(3'd1, 1'b0, 64'h1000_2000_4000_8000, 64'h0100_0200_0400_0800);
        queue_channel(NBINS + 2);
        wait_idle();

        // random phases, with one long receiver hold-off and sender pauses
        n = 0;
        for (int ph = 0; ph < 8; ph++)
        begin
            write_all(3'($urandom), 1'($urandom), {$urandom, $urandom}, {$urandom, $urandom});
            for (int c = 0; c < 6; c++)
            begin
                int len;
                len = ($urandom_range(0, 15) == 0) ? $urandom_range(60, 68)
                                                    : $urandom_range(1, 8);
                queue_channel(len);
                n += len;
            end
            if (ph == 2)
            begin
                stall_long = 1'b1;
                repeat (3000) @(posedge clk);
                stall_long = 1'b0;
            end
            if (ph == 4)
            begin
                while (pending_items.size() != 0)
                    @(posedge clk);
                driver_paused = 1'b1;
                while (expected_bins.size() != 0)
                    @(posedge clk);
                driver_paused = 1'b0;
            end
            wait_idle();
        end

        $display("covered %0d channels, %0d bins checked, clipped and wrapped windows",
                 channels_sent, bins_checked);
        if (errors == 0)
            $display("gaussian_histogram_smoother: match");
        else
            $display("gaussian_histogram_smoother: mismatch");
        $finish;
    end
endmodule

/* gaussian_histogram_smoother.f */
src/ghs_pkg.sv
src/ghs_loader.sv
src/ghs_job_queue.sv
src/ghs_engine.sv
src/gaussian_histogram_smoother.sv
src/ghs_checker.sv
verif/gaussian_histogram_smoother_tb.sv
